// ----- src/arp_cache_and_responder_assert.svh -----
// Assertion shorthands for the top-level block, which checks itself.
`ifndef ARP_CACHE_AND_RESPONDER_ASSERT_SVH
`define ARP_CACHE_AND_RESPONDER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define ARPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/arpc_pkg.sv -----
package arpc_pkg;

    // Cache addresses travel at the width of the largest supported cache.
    localparam int ADDR_W     = 8;
    localparam int CFG_DATA_W = 48;

    localparam logic [15:0] MIN_ARP_LEN = 16'd28;
    localparam logic [15:0] HTYPE_ETH   = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HLEN_ETH    = 8'd6;
    localparam logic [7:0]  PLEN_IPV4   = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    typedef enum logic [0:0] {
        CFG_OWN_IP  = 1'b0,
        CFG_OWN_MAC = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        MODE_HEADER = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_DROP     = 3'd0,
        ST_RECORDED = 3'd1,
        ST_REPLY    = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } t_status;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] payload_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_addr_len;
        logic [7:0]  proto_addr_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] tgt_ip;
        logic [31:0] query_ip;
    } t_arp_in;

    typedef struct packed {
        t_status     status;
        logic [47:0] reply_mac;
        logic [31:0] reply_ip;
        logic [47:0] found_mac;
    } t_arp_out;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_entry;
    } t_mem_req;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_mem_rsp;

endpackage

// ----- src/arp_cache_and_responder.sv -----
// ARP cache and responder. Each transaction on the input channel is either a
// parsed ARP header or a cache lookup, and yields exactly one result. A header
// or lookup walks the whole cache once through a memory with a registered read,
// reading one entry per cycle, after which the result is loaded into the output
// register once that register is free; a malformed header skips the walk and
// goes straight to loading its result. One item is in work at a time; the next
// is taken the cycle after the previous result is loaded into the output
// register, even if that result is still stalled. The cache write for a header
// happens when its result is loaded, before the next item can read, so no
// forwarding is needed. The valid marks are cleared by reset at once, with no
// clearing pass.
`include "arp_cache_and_responder_assert.svh"

module arp_cache_and_responder #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  arpc_pkg::t_cfg_idx                     i_cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  arpc_pkg::t_arp_in                      i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output arpc_pkg::t_arp_out                     o_out
);
    import arpc_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [31:0] r_own_ip;
    t_mem_req    mem_req;
    t_mem_rsp    mem_rsp;

    // The own MAC only sources the reply frame, which is assembled downstream;
    // a write to it is accepted and has no effect on any result here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_OWN_IP)) begin
            r_own_ip <= i_cfg_data[31:0];
        end
    end

    arpc_ctrl #(
        .ENTRIES (CACHE_ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_own_ip    (r_own_ip),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_req       (mem_req),
        .i_rsp       (mem_rsp)
    );

    arpc_mem #(
        .ENTRIES (CACHE_ENTRIES),
        .IW      (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    `ARPC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "accepted item did not occupy the block")
    `ARPC_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result appeared with no item in work")
    `ARPC_ASSERT_SAME(a_reply_fields, i_clk, i_rst_n, o_out_valid && (o_out.status != ST_REPLY), (o_out.reply_ip == 32'd0) && (o_out.reply_mac == 48'd0), "reply fields set without a reply")

endmodule

// ----- src/arpc_mem.sv -----
module arpc_mem #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  arpc_pkg::t_mem_req i_req,
    output arpc_pkg::t_mem_rsp o_rsp
);
    import arpc_pkg::*;

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic               r_rsp_valid;
    t_entry             r_rsp_entry;

    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;

    assign rd_idx = i_req.rd_addr[IW-1:0];
    assign wr_idx = i_req.wr_addr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_idx] <= i_req.wr_entry;
        end
        r_rsp_entry <= r_mem[rd_idx];
    end

    // Valid marks live in flops so that reset empties the cache at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
            r_rsp_valid <= r_valid[rd_idx];
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.entry = r_rsp_entry;

endmodule

// ----- src/arpc_ctrl.sv -----
module arpc_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_own_ip,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  arpc_pkg::t_arp_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output arpc_pkg::t_arp_out o_out,
    output arpc_pkg::t_mem_req o_req,
    input  arpc_pkg::t_mem_rsp i_rsp
);
    import arpc_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state        r_state, n_state;
    t_arp_in       r_item, n_item;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_rd_vld, n_rd_vld;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_found, n_found;
    logic [IW-1:0] r_found_idx, n_found_idx;
    logic [47:0]   r_found_mac, n_found_mac;
    logic          r_free, n_free;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic          r_out_vld, n_out_vld;
    t_arp_out      r_out, n_out;

    logic          hdr_ok;
    logic          issuing;
    logic [31:0]   key_ip;
    logic          want_reply;
    logic          out_free;
    logic [IW-1:0] wr_slot;

    assign hdr_ok = (i_in.payload_len >= MIN_ARP_LEN) && (i_in.hw_type == HTYPE_ETH)
                 && (i_in.proto_type == PTYPE_IPV4) && (i_in.hw_addr_len == HLEN_ETH)
                 && (i_in.proto_addr_len == PLEN_IPV4);
    assign issuing    = r_cnt < CW'(ENTRIES);
    assign key_ip     = (r_item.mode == MODE_LOOKUP) ? r_item.query_ip : r_item.sender_ip;
    assign want_reply = (r_item.opcode == OP_REQUEST) && (r_item.tgt_ip == i_own_ip)
                     && (i_own_ip != 32'd0);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign wr_slot    = r_found ? r_found_idx : (r_free ? r_free_idx : '0);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_drop      = r_drop;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_found_mac = r_found_mac;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out       = r_out;

        o_req.rd_addr  = ADDR_W'(r_cnt[IW-1:0]);
        o_req.wr_en    = 1'b0;
        o_req.wr_addr  = ADDR_W'(wr_slot);
        o_req.wr_entry = '{ip: r_item.sender_ip, mac: r_item.sender_mac};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_drop  = (i_in.mode == MODE_HEADER) && !hdr_ok;
                    n_cnt   = '0;
                    n_found = 1'b0;
                    n_free  = 1'b0;
                    n_state = n_drop ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // One read issued per cycle; its data is checked in the next cycle.
                if (issuing) begin
                    n_cnt    = r_cnt + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt[IW-1:0];
                end
                if (r_rd_vld) begin
                    if (i_rsp.valid && (i_rsp.entry.ip == key_ip) && !r_found) begin
                        n_found     = 1'b1;
                        n_found_idx = r_rd_idx;
                        n_found_mac = i_rsp.entry.mac;
                    end
                    if (!i_rsp.valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_rd_idx;
                    end
                end
                if (!issuing && !r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = '{status: ST_DROP, reply_mac: '0, reply_ip: '0,
                                  found_mac: '0};
                    if (r_item.mode == MODE_LOOKUP) begin
                        n_out.status    = r_found ? ST_HIT : ST_MISS;
                        n_out.found_mac = r_found ? r_found_mac : '0;
                    end else if (!r_drop) begin
                        o_req.wr_en = 1'b1;
                        if (want_reply) begin
                            n_out.status    = ST_REPLY;
                            n_out.reply_mac = r_item.sender_mac;
                            n_out.reply_ip  = r_item.sender_ip;
                        end else begin
                            n_out.status = ST_RECORDED;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_drop      <= n_drop;
        r_cnt       <= n_cnt;
        r_rd_idx    <= n_rd_idx;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_found_mac <= n_found_mac;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule
